FILE: design/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg: shared definitions of the frame call stack
// Constants, command and status codes, and the control and status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int DEPTH       = 256;
    localparam int CAP_LIMIT   = 199;
    localparam int CAP         = (DEPTH - 1 < CAP_LIMIT) ? DEPTH - 1 : CAP_LIMIT;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int IDX_W       = $clog2(CAP + 1);
    localparam int FRAME_SLOTS = 4;
    localparam int RSV_W       = (IDX_W > 8) ? IDX_W + 1 : 9;

    typedef enum logic [2:0] {
        CMD_PUSH_INT   = 3'd0,
        CMD_PUSH_FLT   = 3'd1,
        CMD_POP_INT    = 3'd2,
        CMD_POP_FLT    = 3'd3,
        CMD_RESERVE    = 3'd4,
        CMD_PUSH_FRAME = 3'd5,
        CMD_POP_FRAME  = 3'd6,
        CMD_RESET      = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BOTTOM    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        SRC_INT,
        SRC_FLT,
        SRC_BASE,
        SRC_TIME,
        SRC_OFF,
        SRC_SUB
    } t_src;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_INT,
        CAP_FLT,
        CAP_SUB,
        CAP_OFF,
        CAP_TIME,
        CAP_BASE
    } t_cap;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_RESERVE,
        DP_CLEAR,
        DP_ECHO,
        DP_BOTTOM,
        DP_FRAME_OPEN,
        DP_TOP_TO_BASE,
        DP_READ,
        DP_POST
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH,
        S_POP_CAP,
        S_FPUSH,
        S_FOPEN,
        S_FPOP_SET,
        S_FPOP,
        S_POST
    } t_state;

    typedef struct packed {
        logic    in_ready;
        t_dp_op  op;
        t_src    src;
        logic    wr;
        t_cap    cap;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        t_cmd cmd;
        logic top_full;
        logic pop_block;
        logic fpush_full;
        logic base_zero;
        logic rsv_sat;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: design/fcs_in_if.sv
// ----------------------------------------------------------------------------
// fcs_in_if: command channel of the frame call stack
// Valid and ready handshake carrying one stack command and its operands.
// ----------------------------------------------------------------------------
interface fcs_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] int_value;
    logic [31:0]        float_value;
    logic               unchecked;
    logic [9:0]         byte_count;
    logic signed [31:0] cur_offset;
    logic signed [31:0] cur_sub;
    logic [31:0]        cur_time;

    modport source (output valid, command, int_value, float_value, unchecked,
                    byte_count, cur_offset, cur_sub, cur_time, input ready);
    modport sink (input valid, command, int_value, float_value, unchecked,
                  byte_count, cur_offset, cur_sub, cur_time, output ready);
endinterface

FILE: design/fcs_out_if.sv
// ----------------------------------------------------------------------------
// fcs_out_if: result channel of the frame call stack
// Valid and ready handshake carrying one result per command.
// ----------------------------------------------------------------------------
interface fcs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] int_result;
    logic [31:0]        float_result;
    logic signed [31:0] new_offset;
    logic signed [31:0] new_sub;
    logic [31:0]        new_time;
    logic [1:0]         status;

    modport source (output valid, int_result, float_result, new_offset, new_sub,
                    new_time, status, input ready);
    modport sink (input valid, int_result, float_result, new_offset, new_sub,
                  new_time, status, output ready);
endinterface

FILE: design/fcs_datapath.sv
// ----------------------------------------------------------------------------
// fcs_datapath: stack storage, pointers and value conversion
// Holds the two slot views, the top and base pointers, a two-stage
// integer/float conversion pipe, the result fields and the output register.
// ----------------------------------------------------------------------------
module fcs_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fcs_in_if.sink            i_in,
    fcs_out_if.source         o_out,
    input  fcs_pkg::t_dp_cmd  i_cmd,
    output fcs_pkg::t_dp_stat o_stat
);

    function automatic logic [31:0] f_trunc(input logic [31:0] b);
        logic [7:0]  ex;
        logic [7:0]  p;
        logic [31:0] mant;
        logic [31:0] mag;
        ex   = b[30:23];
        p    = ex - 8'd127;
        mant = {8'd0, 1'b1, b[22:0]};
        if (p >= 8'd23) begin
            mag = mant << (p - 8'd23);
        end else begin
            mag = mant >> (8'd23 - p);
        end
        if (ex == 8'hFF && b[22:0] != 23'd0) begin
            f_trunc = '0;
        end else if (ex < 8'd127) begin
            f_trunc = '0;
        end else if (p >= 8'd31) begin
            f_trunc = b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            f_trunc = b[31] ? (32'd0 - mag) : mag;
        end
    endfunction

    logic [31:0] r_int_mem [fcs_pkg::DEPTH];
    logic [31:0] r_flt_mem [fcs_pkg::DEPTH];
    logic [fcs_pkg::DEPTH-1:0] r_valid;

    logic [fcs_pkg::IDX_W-1:0] r_top;
    logic [fcs_pkg::IDX_W-1:0] r_base;

    fcs_pkg::t_cmd      r_cmd;
    logic               r_unchecked;
    logic [9:0]         r_bytes;
    logic [31:0]        r_ival;
    logic [31:0]        r_fval;
    logic [31:0]        r_coff;
    logic [31:0]        r_csub;
    logic [31:0]        r_ctime;

    logic [31:0] r_ir;
    logic [31:0] r_fr;
    logic [31:0] r_noff;
    logic [31:0] r_nsub;
    logic [31:0] r_ntime;

    logic [31:0] r_rd_int;
    logic [31:0] r_rd_flt;
    logic        r_rd_ok;

    logic [31:0] r_s1_raw;
    logic        r_s1_isflt;
    logic        r_s1_sign;
    logic [31:0] r_s1_mag;
    logic [4:0]  r_s1_lz;
    logic [31:0] r_s1_trunc;
    logic [31:0] r_s2_raw;
    logic        r_s2_isflt;
    logic [31:0] r_s2_trunc;
    logic [31:0] r_s2_fbits;

    logic        r_out_vld;
    logic [31:0] r_o_ir;
    logic [31:0] r_o_fr;
    logic [31:0] r_o_noff;
    logic [31:0] r_o_nsub;
    logic [31:0] r_o_ntime;
    logic [1:0]  r_o_status;

    logic                       load;
    logic                       out_xfer;
    logic [31:0]                src_raw;
    logic                       src_isflt;
    logic [31:0]                src_mag;
    logic [4:0]                 src_lz;
    logic [31:0]                norm;
    logic                       rnd;
    logic [24:0]                mant_sum;
    logic [7:0]                 fexp;
    logic [31:0]                fbits;
    logic [31:0]                rd_iv;
    logic [31:0]                rd_fv;
    logic [fcs_pkg::RSV_W-1:0]  rsv_sum;
    logic [fcs_pkg::IDX_W-1:0]  sat_base;
    logic [fcs_pkg::ADDR_W-1:0] rd_addr;
    logic [fcs_pkg::ADDR_W-1:0] wr_addr;
    logic [31:0]                wr_iv;
    logic [31:0]                wr_fv;

    assign load     = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign i_in.ready = i_cmd.in_ready;

    always_comb begin
        unique case (i_cmd.src)
            fcs_pkg::SRC_INT:  begin src_raw = r_ival;  src_isflt = 1'b0; end
            fcs_pkg::SRC_FLT:  begin src_raw = r_fval;  src_isflt = 1'b1; end
            fcs_pkg::SRC_BASE: begin src_raw = 32'(r_base); src_isflt = 1'b0; end
            fcs_pkg::SRC_TIME: begin src_raw = r_ctime; src_isflt = 1'b1; end
            fcs_pkg::SRC_OFF:  begin src_raw = r_coff;  src_isflt = 1'b0; end
            fcs_pkg::SRC_SUB:  begin src_raw = r_csub;  src_isflt = 1'b0; end
            default:           begin src_raw = r_ival;  src_isflt = 1'b0; end
        endcase
        src_mag = src_raw[31] ? (32'd0 - src_raw) : src_raw;
        src_lz  = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (src_mag[i]) begin
                src_lz = 5'(31 - i);
            end
        end
    end

    always_comb begin
        norm     = r_s1_mag << r_s1_lz;
        rnd      = norm[7] && ((|norm[6:0]) || norm[8]);
        mant_sum = {1'b0, norm[31:8]} + {24'd0, rnd};
        fexp     = 8'd158 - {3'd0, r_s1_lz} + {7'd0, mant_sum[24]};
        if (r_s1_mag == 32'd0) begin
            fbits = '0;
        end else begin
            fbits = {r_s1_sign, fexp, mant_sum[24] ? 23'd0 : mant_sum[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_raw   <= src_raw;
        r_s1_isflt <= src_isflt;
        r_s1_sign  <= src_raw[31];
        r_s1_mag   <= src_mag;
        r_s1_lz    <= src_lz;
        r_s1_trunc <= f_trunc(src_raw);
        r_s2_raw   <= r_s1_raw;
        r_s2_isflt <= r_s1_isflt;
        r_s2_trunc <= r_s1_trunc;
        r_s2_fbits <= fbits;
    end

    assign rd_iv    = r_rd_ok ? r_rd_int : 32'd0;
    assign rd_fv    = r_rd_ok ? r_rd_flt : 32'd0;
    assign rsv_sum  = fcs_pkg::RSV_W'(r_base) + fcs_pkg::RSV_W'(r_bytes[9:2]);
    assign rd_addr  = fcs_pkg::ADDR_W'(r_top - fcs_pkg::IDX_W'(1));
    assign wr_addr  = fcs_pkg::ADDR_W'(r_top);
    assign wr_iv    = r_s2_isflt ? r_s2_trunc : r_s2_raw;
    assign wr_fv    = r_s2_isflt ? r_s2_raw : r_s2_fbits;

    always_comb begin
        if (rd_iv[31]) begin
            sat_base = '0;
        end else if (rd_iv > 32'(fcs_pkg::CAP)) begin
            sat_base = fcs_pkg::IDX_W'(fcs_pkg::CAP);
        end else begin
            sat_base = rd_iv[fcs_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_int_mem[wr_addr] <= wr_iv;
            r_flt_mem[wr_addr] <= wr_fv;
        end
        if (i_cmd.op == fcs_pkg::DP_READ) begin
            r_rd_int <= r_int_mem[rd_addr];
            r_rd_flt <= r_flt_mem[rd_addr];
            r_rd_ok  <= (r_top != '0) && r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd       <= fcs_pkg::t_cmd'(i_in.command);
            r_unchecked <= i_in.unchecked;
            r_bytes     <= i_in.byte_count;
            r_ival      <= i_in.int_value;
            r_fval      <= i_in.float_value;
            r_coff      <= i_in.cur_offset;
            r_csub      <= i_in.cur_sub;
            r_ctime     <= i_in.cur_time;
            r_ir        <= '0;
            r_fr        <= '0;
            r_noff      <= '0;
            r_nsub      <= '0;
            r_ntime     <= '0;
        end else begin
            case (i_cmd.op)
                fcs_pkg::DP_CLEAR: begin
                    r_nsub <= r_csub;
                end
                fcs_pkg::DP_ECHO: begin
                    r_noff  <= r_coff;
                    r_nsub  <= r_csub;
                    r_ntime <= r_ctime;
                end
                fcs_pkg::DP_BOTTOM: begin
                    r_noff  <= r_coff;
                    r_nsub  <= '1;
                    r_ntime <= r_ctime;
                end
                fcs_pkg::DP_FRAME_OPEN: begin
                    r_nsub <= '1;
                end
                default: begin
                end
            endcase
            case (i_cmd.cap)
                fcs_pkg::CAP_INT:  r_ir    <= rd_iv;
                fcs_pkg::CAP_FLT:  r_fr    <= rd_fv;
                fcs_pkg::CAP_SUB:  r_nsub  <= rd_iv;
                fcs_pkg::CAP_OFF:  r_noff  <= rd_iv;
                fcs_pkg::CAP_TIME: r_ntime <= rd_fv;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_base <= '0;
        end else begin
            if (i_cmd.wr) begin
                r_top <= r_top + fcs_pkg::IDX_W'(1);
            end
            case (i_cmd.op)
                fcs_pkg::DP_RESERVE: begin
                    r_top <= rsv_sum > fcs_pkg::RSV_W'(fcs_pkg::CAP)
                           ? fcs_pkg::IDX_W'(fcs_pkg::CAP) : rsv_sum[fcs_pkg::IDX_W-1:0];
                end
                fcs_pkg::DP_CLEAR: begin
                    r_top  <= '0;
                    r_base <= '0;
                end
                fcs_pkg::DP_FRAME_OPEN: r_base <= r_top;
                fcs_pkg::DP_TOP_TO_BASE: r_top <= r_base;
                fcs_pkg::DP_READ: begin
                    if (r_top != '0) begin
                        r_top <= r_top - fcs_pkg::IDX_W'(1);
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.cap == fcs_pkg::CAP_BASE) begin
                r_base <= sat_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.op == fcs_pkg::DP_POST) begin
            r_out_vld <= 1'b1;
        end else if (out_xfer) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == fcs_pkg::DP_POST) begin
            r_o_ir     <= r_ir;
            r_o_fr     <= r_fr;
            r_o_noff   <= r_noff;
            r_o_nsub   <= r_nsub;
            r_o_ntime  <= r_ntime;
            r_o_status <= i_cmd.status;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.int_result   = r_o_ir;
    assign o_out.float_result = r_o_fr;
    assign o_out.new_offset   = r_o_noff;
    assign o_out.new_sub      = r_o_nsub;
    assign o_out.new_time     = r_o_ntime;
    assign o_out.status       = r_o_status;

    always_comb begin
        o_stat.in_valid   = i_in.valid;
        o_stat.cmd        = r_cmd;
        o_stat.top_full   = r_top >= fcs_pkg::IDX_W'(fcs_pkg::CAP);
        o_stat.pop_block  = (!r_unchecked && r_top <= r_base) || r_top == '0;
        o_stat.fpush_full = ({1'b0, r_top} + (fcs_pkg::IDX_W + 1)'(fcs_pkg::FRAME_SLOTS))
                            > (fcs_pkg::IDX_W + 1)'(fcs_pkg::CAP);
        o_stat.base_zero  = r_base == '0;
        o_stat.rsv_sat    = rsv_sum > fcs_pkg::RSV_W'(fcs_pkg::CAP);
        o_stat.out_busy   = r_out_vld && !o_out.ready;
    end

endmodule

FILE: design/fcs_ctrl.sv
// ----------------------------------------------------------------------------
// fcs_ctrl: command sequencer of the frame call stack
// Decodes each command and steps the datapath through its writes, reads
// and result posting.
// ----------------------------------------------------------------------------
module fcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcs_pkg::t_dp_stat i_stat,
    output fcs_pkg::t_dp_cmd  o_cmd
);

    fcs_pkg::t_state  r_state;
    fcs_pkg::t_state  n_state;
    logic [2:0]       r_k;
    logic [2:0]       n_k;
    fcs_pkg::t_status r_status;
    fcs_pkg::t_status n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fcs_pkg::S_IDLE;
            r_k      <= '0;
            r_status <= fcs_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_status = r_status;
        o_cmd    = '{in_ready: 1'b0, op: fcs_pkg::DP_NOP, src: fcs_pkg::SRC_INT,
                     wr: 1'b0, cap: fcs_pkg::CAP_NONE, status: r_status};
        unique case (r_state)
            fcs_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state  = fcs_pkg::S_DECODE;
                    n_status = fcs_pkg::ST_OK;
                    n_k      = '0;
                end
            end
            fcs_pkg::S_DECODE: begin
                n_state = fcs_pkg::S_POST;
                unique case (i_stat.cmd) inside
                    fcs_pkg::CMD_PUSH_INT, fcs_pkg::CMD_PUSH_FLT: begin
                        if (i_stat.top_full) begin
                            n_status = fcs_pkg::ST_OVERFLOW;
                        end else begin
                            n_state = fcs_pkg::S_PUSH;
                        end
                    end
                    fcs_pkg::CMD_POP_INT, fcs_pkg::CMD_POP_FLT: begin
                        if (i_stat.pop_block) begin
                            n_status = fcs_pkg::ST_UNDERFLOW;
                        end else begin
                            o_cmd.op = fcs_pkg::DP_READ;
                            n_state  = fcs_pkg::S_POP_CAP;
                        end
                    end
                    fcs_pkg::CMD_RESERVE: begin
                        o_cmd.op = fcs_pkg::DP_RESERVE;
                        if (i_stat.rsv_sat) begin
                            n_status = fcs_pkg::ST_OVERFLOW;
                        end
                    end
                    fcs_pkg::CMD_PUSH_FRAME: begin
                        if (i_stat.fpush_full) begin
                            o_cmd.op = fcs_pkg::DP_ECHO;
                            n_status = fcs_pkg::ST_OVERFLOW;
                        end else begin
                            n_state = fcs_pkg::S_FPUSH;
                        end
                    end
                    fcs_pkg::CMD_POP_FRAME: begin
                        if (i_stat.base_zero) begin
                            o_cmd.op = fcs_pkg::DP_BOTTOM;
                            n_status = fcs_pkg::ST_BOTTOM;
                        end else begin
                            n_state = fcs_pkg::S_FPOP_SET;
                        end
                    end
                    default: begin
                        o_cmd.op = fcs_pkg::DP_CLEAR;
                    end
                endcase
            end
            fcs_pkg::S_PUSH: begin
                o_cmd.src = (i_stat.cmd == fcs_pkg::CMD_PUSH_FLT)
                          ? fcs_pkg::SRC_FLT : fcs_pkg::SRC_INT;
                n_k = r_k + 3'd1;
                if (r_k == 3'd2) begin
                    o_cmd.wr = 1'b1;
                    n_state  = fcs_pkg::S_POST;
                end
            end
            fcs_pkg::S_POP_CAP: begin
                o_cmd.cap = (i_stat.cmd == fcs_pkg::CMD_POP_FLT)
                          ? fcs_pkg::CAP_FLT : fcs_pkg::CAP_INT;
                n_state = fcs_pkg::S_POST;
            end
            fcs_pkg::S_FPUSH: begin
                case (r_k)
                    3'd0:    o_cmd.src = fcs_pkg::SRC_BASE;
                    3'd1:    o_cmd.src = fcs_pkg::SRC_TIME;
                    3'd2:    o_cmd.src = fcs_pkg::SRC_OFF;
                    default: o_cmd.src = fcs_pkg::SRC_SUB;
                endcase
                o_cmd.wr = r_k >= 3'd2;
                n_k      = r_k + 3'd1;
                if (r_k == 3'd5) begin
                    n_state = fcs_pkg::S_FOPEN;
                end
            end
            fcs_pkg::S_FOPEN: begin
                o_cmd.op = fcs_pkg::DP_FRAME_OPEN;
                n_state  = fcs_pkg::S_POST;
            end
            fcs_pkg::S_FPOP_SET: begin
                o_cmd.op = fcs_pkg::DP_TOP_TO_BASE;
                n_state  = fcs_pkg::S_FPOP;
            end
            fcs_pkg::S_FPOP: begin
                if (r_k < 3'd4) begin
                    o_cmd.op = fcs_pkg::DP_READ;
                end
                case (r_k)
                    3'd1:    o_cmd.cap = fcs_pkg::CAP_SUB;
                    3'd2:    o_cmd.cap = fcs_pkg::CAP_OFF;
                    3'd3:    o_cmd.cap = fcs_pkg::CAP_TIME;
                    3'd4:    o_cmd.cap = fcs_pkg::CAP_BASE;
                    default: o_cmd.cap = fcs_pkg::CAP_NONE;
                endcase
                n_k = r_k + 3'd1;
                if (r_k == 3'd4) begin
                    n_state = fcs_pkg::S_POST;
                end
            end
            fcs_pkg::S_POST: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = fcs_pkg::DP_POST;
                    n_state  = fcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fcs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/frame_call_stack.sv
// ----------------------------------------------------------------------------
// frame_call_stack: value stack with call frames for a script machine
// Top level joining the command sequencer and the stack datapath.
// ----------------------------------------------------------------------------
// Each transfer on the command channel yields exactly one transfer on the
// result channel. Commands run one at a time through a single-port slot
// memory: a push passes its value through the conversion pipe before the
// slot write, a push frame feeds four slot writes back to back through the
// conversion pipe and a pop frame makes four reads. The memory needs no
// clearing pass: a valid bit per slot makes never-written slots read zero.
module frame_call_stack (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcs_in_if.sink    i_in,
    fcs_out_if.source o_out
);

    fcs_pkg::t_dp_cmd  w_cmd;
    fcs_pkg::t_dp_stat w_stat;

    fcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    fcs_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule
